/* sv/lph_pkg.sv */
// Shared types and constants for the linear probing hash table.
`default_nettype none
package lph_pkg;

  // The home slot is taken as the low key bits, so the capacity is a power of two.
  localparam int CAPACITY = 1024;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int KEY_W    = 32;
  localparam int VAL_W    = 32;
  localparam int CURSOR_W = 11;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_FIND   = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_FETCH  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_NO_DATA   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SLOT_EMPTY = 2'd0,
    SLOT_LIVE  = 2'd1,
    SLOT_TOMB  = 2'd2,
    SLOT_SPARE = 2'd3
  } mark_t;

  typedef struct packed {
    action_t              action;
    logic [KEY_W-1:0]     key;
    logic [VAL_W-1:0]     value;
    logic [CURSOR_W-1:0]  cursor;
  } req_t;

  typedef struct packed {
    status_t              status;
    logic [KEY_W-1:0]     found_key;
    logic [VAL_W-1:0]     found_value;
    logic [CURSOR_W-1:0]  next_cursor;
  } rsp_t;

  typedef struct packed {
    mark_t             mark;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
  } slot_t;

  typedef struct packed {
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    slot_t             wr_data;
  } mem_cmd_t;

endpackage
`default_nettype wire

/* sv/lph_mem.sv */
// Slot memory: one write port and one read port with registered read data.
`default_nettype none
module lph_mem (
  input  wire logic              clk,
  input  wire lph_pkg::mem_cmd_t cmd,
  output lph_pkg::slot_t         rd_data
);
  import lph_pkg::*;

  slot_t ram [CAPACITY];

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      ram[cmd.wr_addr] <= cmd.wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= ram[cmd.rd_addr];
    end
  end

endmodule
`default_nettype wire

/* sv/lph_ctrl.sv */
// Probe sequencer: clears the table after reset and walks probe chains one slot per cycle.
`default_nettype none
module lph_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  input  wire lph_pkg::req_t     req,
  output logic                   req_ready,
  output lph_pkg::mem_cmd_t      cmd,
  input  wire lph_pkg::slot_t    rd_data,
  output logic                   res_valid,
  output lph_pkg::rsp_t          res,
  input  wire logic              res_take
);
  import lph_pkg::*;

  localparam logic [IDX_W-1:0]    LAST_IDX   = IDX_W'(CAPACITY - 1);
  localparam logic [CURSOR_W-1:0] LAST_CURSOR = CURSOR_W'(CAPACITY - 1);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_PROBE,
    S_DONE
  } state_t;

  state_t           state;
  req_t             item;
  logic [IDX_W-1:0] pos;
  logic [IDX_W-1:0] cnt;
  logic [IDX_W-1:0] clr_addr;

  logic             accept;
  logic [IDX_W-1:0] start;
  logic [IDX_W-1:0] pos_inc;
  logic             last;
  logic             finish;
  logic             wr_slot;
  slot_t            wr_word;
  rsp_t             result;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign res_valid = (state == S_DONE);
  assign start     = (req.action == ACT_FETCH) ? req.cursor[IDX_W-1:0] : req.key[IDX_W-1:0];
  assign pos_inc   = pos + 1'b1;
  assign last      = (item.action == ACT_FETCH) ? (pos == LAST_IDX) : (cnt == LAST_IDX);

  // Decision on the slot whose data has just come back from the memory.
  always_comb begin
    finish  = 1'b0;
    wr_slot = 1'b0;
    wr_word = '{mark: SLOT_EMPTY, key: '0, value: '0};
    result  = '{status: ST_OK, found_key: '0, found_value: '0, next_cursor: '0};
    case (item.action)
      ACT_INSERT: begin
        if (rd_data.mark == SLOT_EMPTY) begin
          finish  = 1'b1;
          wr_slot = 1'b1;
          wr_word = '{mark: SLOT_LIVE, key: item.key, value: item.value};
        end else if (last) begin
          finish        = 1'b1;
          result.status = ST_FULL;
        end
      end
      ACT_FIND, ACT_DELETE: begin
        if (rd_data.mark == SLOT_EMPTY) begin
          finish        = 1'b1;
          result.status = ST_NOT_FOUND;
        end else if (rd_data.mark == SLOT_LIVE && rd_data.key == item.key) begin
          finish = 1'b1;
          if (item.action == ACT_DELETE) begin
            wr_slot = 1'b1;
            wr_word = '{mark: SLOT_TOMB, key: '0, value: '0};
          end else begin
            result.found_key   = rd_data.key;
            result.found_value = rd_data.value;
          end
        end else if (last) begin
          finish        = 1'b1;
          result.status = ST_NOT_FOUND;
        end
      end
      ACT_FETCH: begin
        if (rd_data.mark == SLOT_LIVE) begin
          finish             = 1'b1;
          result.found_key   = rd_data.key;
          result.found_value = rd_data.value;
          result.next_cursor = CURSOR_W'({1'b0, pos} + (IDX_W + 1)'(1));
        end else if (last) begin
          finish             = 1'b1;
          result.status      = ST_NO_DATA;
          result.next_cursor = item.cursor;
        end
      end
      default: begin
        finish = 1'b1;
      end
    endcase
  end

  // No read meets a write: a probe writes only as it finishes, and clearing reads nothing.
  always_comb begin
    cmd.rd_en   = 1'b0;
    cmd.rd_addr = pos_inc;
    cmd.wr_en   = 1'b0;
    cmd.wr_addr = pos;
    cmd.wr_data = wr_word;
    case (state)
      S_CLEAR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = clr_addr;
        cmd.wr_data = '{mark: SLOT_EMPTY, key: '0, value: '0};
      end
      S_IDLE: begin
        cmd.rd_en   = accept;
        cmd.rd_addr = start;
      end
      S_PROBE: begin
        cmd.rd_en = !finish;
        cmd.wr_en = finish && wr_slot;
      end
      default: begin
        cmd.rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_IDX) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            item <= req;
            pos  <= start;
            cnt  <= '0;
            if (req.action == ACT_FETCH && req.cursor > LAST_CURSOR) begin
              res   <= '{status: ST_NO_DATA, found_key: '0, found_value: '0,
                         next_cursor: req.cursor};
              state <= S_DONE;
            end else begin
              state <= S_PROBE;
            end
          end
        end
        S_PROBE: begin
          if (finish) begin
            res   <= result;
            state <= S_DONE;
          end else begin
            pos <= pos_inc;
            cnt <= cnt + 1'b1;
          end
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* sv/linear_probe_hash_table.sv */
// Probing: a request visits P slots before its response is formed, where P is the number of slots
// probed (1..1024, or 0 for a fetch whose cursor lies past the table).
// Requests: one at a time, the next taken once the response leaves the sequencer; the single read port
// of the slot memory visits one slot per cycle, and fetch scans from the cursor one slot per cycle.
// Reset: synchronous; afterwards a clearing pass marks every slot free,
// with req_stall held high until it completes.
// Top level of the linear probing hash table: sequencer, slot memory and response register.
`default_nettype none
module linear_probe_hash_table (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  input  wire lph_pkg::req_t  req,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output lph_pkg::rsp_t       rsp
);
  import lph_pkg::*;

  logic     req_ready;
  mem_cmd_t cmd;
  slot_t    rd_data;
  logic     res_valid;
  rsp_t     res;
  logic     res_take;

  lph_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .req_ready (req_ready),
    .cmd       (cmd),
    .rd_data   (rd_data),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  lph_mem u_mem (
    .clk     (clk),
    .cmd     (cmd),
    .rd_data (rd_data)
  );

  assign req_stall = !req_ready;
  assign res_take  = res_valid && (!rsp_valid || !rsp_stall);

  // The response register frees the sequencer while a response waits downstream.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      rsp <= res;
    end
  end

`ifndef ASSERT_OFF
  a_clear_after_reset: assert property (@(posedge clk) rst |=> req_stall)
    else $error("request accepted while the table is being cleared");

  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    !(cmd.wr_en && cmd.rd_en && cmd.wr_addr == cmd.rd_addr))
    else $error("slot read and written in the same cycle");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("second request taken while one is in progress");

  a_no_data_clean: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == ST_NO_DATA) |-> (rsp.found_key == '0 && rsp.found_value == '0))
    else $error("empty fetch response carries data");
`endif

endmodule
`default_nettype wire
